// File: rtl/trmt_pkg.sv
// ----------------------------------------------------------------------------
// trmt_pkg: shared types and constants for the typed region map table
// Opcodes, status codes, controller states and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package trmt_pkg;

  localparam int ADDR_FIELD_W = 32;
  localparam int KIND_W       = 4;
  localparam int TOTAL_W      = 33;
  localparam int USED_W       = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_CAP = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_TOTAL  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_FULL     = 2'd2,
    STS_UNMAPPED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_DATA,
    S_EMIT,
    S_TAIL,
    S_FLUSH,
    S_DONE
  } fsm_t;

endpackage

`default_nettype wire

// File: rtl/trmt_if.sv
// ----------------------------------------------------------------------------
// trmt_if: request and response channels of the region map table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface trmt_req_if;
  import trmt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [ADDR_FIELD_W-1:0] range_start;
  logic [ADDR_FIELD_W-1:0] range_end;
  logic [KIND_W-1:0]       region_kind;
  logic [ADDR_FIELD_W-1:0] lookup_address;

  modport source (output valid, opcode, range_start, range_end, region_kind,
                  lookup_address, input ready);
  modport sink   (input valid, opcode, range_start, range_end, region_kind,
                  lookup_address, output ready);
endinterface

interface trmt_rsp_if;
  import trmt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [KIND_W-1:0]  found_kind;
  logic [TOTAL_W-1:0] total_bytes;
  logic [USED_W-1:0]  regions_used;

  modport source (output valid, status, found_kind, total_bytes, regions_used,
                  input ready);
  modport sink   (input valid, status, found_kind, total_bytes, regions_used,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/typed_region_map_table_unit.sv
// ----------------------------------------------------------------------------
// typed_region_map_table_unit: sorted table of typed address regions
// Define, lookup and per-type total over a table held in a two-bank RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer (define range type, lookup address,
//   total size of type); rsp returns exactly one result per command.
//   Commands are taken one at a time. A lookup or total scans the regions in
//   order through the single RAM read port; a lookup stops at the first region
//   that holds the address. A define scans all regions and emits pieces while
//   scanning (one per cycle, written entries plus merges), then places the new
//   range if still unplaced and writes the last held piece. An empty define or
//   unused opcode skips the scan.
//   A define builds the new table in the other RAM bank and switches banks
//   only when the result fits, so a full table stays untouched.
//   Reset empties the table at once (count to zero, no clearing pass).
//   The result sits in an output register: the next command is accepted while
//   it waits, and a finished command holds until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_region_map_table_unit #(
  parameter int MAX_REGIONS = 64,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  trmt_req_if.sink    req,
  trmt_rsp_if.source  rsp
);
  import trmt_pkg::*;

  localparam int AW    = ADDR_WIDTH;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int WC_W  = $clog2(MAX_REGIONS + 3);
  localparam int ENT_W = 2 * AW + KIND_W;
  localparam int SW    = ((AW + 1 > TOTAL_W) ? AW + 1 : TOTAL_W) + 1;

  fsm_t state, state_next;

  logic              bank;
  logic [CNT_W-1:0]  count, idx;
  opcode_t           op;
  logic [AW-1:0]     s, e, a;
  logic [KIND_W-1:0] t;
  status_t           sts;
  logic [KIND_W-1:0] found;
  logic [TOTAL_W-1:0] acc;

  logic              placed, lo_v, nw_v, hi_v;
  logic [AW-1:0]     lo_l, hi_f, ent_f, ent_l;
  logic [KIND_W-1:0] ent_k;

  // held entry: last one produced, not yet written, open to merging
  logic              h_v, h_new;
  logic [AW-1:0]     h_f, h_l;
  logic [KIND_W-1:0] h_k;
  logic [WC_W-1:0]   widx;

  logic              out_v, out_load, req_ready, rd_en, emit, flush, em_wr;
  logic [1:0]        o_status;
  logic [KIND_W-1:0] o_found;
  logic [TOTAL_W-1:0] o_total;
  logic [USED_W-1:0] o_used;

  logic [AW-1:0]     c_f, c_l, nh_f, nh_l;
  logic [KIND_W-1:0] c_k, nh_k;
  logic              c_new, nh_v, nh_new;

  logic              ram_we;
  logic [IDX_W:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [AW-1:0]     rd_f, rd_l;
  logic [KIND_W-1:0] rd_k;

  logic              d_below, d_above, d_lo, d_hi, d_nw, hit, last_emit, commit;
  logic [AW:0]       h_succ, size;
  logic [SW-1:0]     sum;

  trmt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (2 << IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_f = ram_rdata[ENT_W-1 -: AW];
  assign rd_l = ram_rdata[KIND_W +: AW];
  assign rd_k = ram_rdata[KIND_W-1:0];

  assign ram_raddr = {bank, idx[IDX_W-1:0]};
  assign ram_waddr = {~bank, widx[IDX_W-1:0]};
  assign ram_wdata = {h_f, h_l, h_k};
  assign ram_we    = em_wr && (widx < WC_W'(MAX_REGIONS));

  // split of the region just read against the define range
  assign d_below = rd_l < s;
  assign d_above = rd_f > e;
  assign d_lo    = d_below || (!d_above && rd_f < s);
  assign d_hi    = d_above || (!d_below && rd_l > e);
  assign d_nw    = !placed && !d_below;
  assign hit     = (a >= rd_f) && (a <= rd_l);

  assign size = {1'b0, rd_l} - {1'b0, rd_f} + (AW+1)'(1);
  assign sum  = SW'(acc) + SW'(size);

  assign h_succ    = {1'b0, h_l} + (AW+1)'(1);
  assign last_emit = lo_v ? !(nw_v || hi_v) : (nw_v ? !hi_v : 1'b1);
  assign commit    = (op == OP_DEFINE) && (sts == STS_OK) &&
                     (widx <= WC_W'(MAX_REGIONS));

  assign out_load  = (state == S_DONE) && (!out_v || rsp.ready);
  assign req.ready = req_ready;

  assign rsp.valid        = out_v;
  assign rsp.status       = o_status;
  assign rsp.found_kind   = o_found;
  assign rsp.total_bytes  = o_total;
  assign rsp.regions_used = o_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_en      = 1'b0;
    emit       = 1'b0;
    flush      = 1'b0;
    c_f        = s;
    c_l        = e;
    c_k        = t;
    c_new      = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) state_next = S_START;
      end
      S_START: begin
        if ((op == OP_DEFINE && s >= e) || op == OP_NONE) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_READ: begin
        if (idx != count) begin
          rd_en      = 1'b1;
          state_next = S_DATA;
        end else if (op == OP_DEFINE) begin
          state_next = S_TAIL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DATA: begin
        if (op == OP_DEFINE) begin
          state_next = (d_lo || d_nw || d_hi) ? S_EMIT : S_READ;
        end else if (op == OP_LOOKUP && hit) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_EMIT: begin
        emit = 1'b1;
        if (lo_v) begin
          c_f = ent_f; c_l = lo_l; c_k = ent_k; c_new = 1'b0;
        end else if (!nw_v) begin
          c_f = hi_f; c_l = ent_l; c_k = ent_k; c_new = 1'b0;
        end
        if (last_emit) state_next = S_READ;
      end
      S_TAIL: begin
        emit       = !placed;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        flush      = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // merge with the entry before the new range, then with the one after it
  always_comb begin
    em_wr  = 1'b0;
    nh_v   = h_v;
    nh_new = h_new;
    nh_f   = h_f;
    nh_l   = h_l;
    nh_k   = h_k;
    if (flush) begin
      em_wr = h_v;
      nh_v  = 1'b0;
    end else if (emit) begin
      if (c_new && h_v && h_k == t && h_succ == {1'b0, c_f}) begin
        nh_l   = c_l;
        nh_new = 1'b1;
      end else if (!c_new && h_v && h_new && c_k == t && h_succ == {1'b0, c_f}) begin
        nh_l   = c_l;
        nh_new = 1'b0;
      end else begin
        em_wr  = h_v;
        nh_v   = 1'b1;
        nh_new = c_new;
        nh_f   = c_f;
        nh_l   = c_l;
        nh_k   = c_k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
      out_v <= 1'b0;
    end else begin
      if (out_load) out_v <= 1'b1;
      else if (rsp.ready) out_v <= 1'b0;
      if (out_load && commit) begin
        count <= CNT_W'(widx);
        bank  <= ~bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op <= opcode_t'(req.opcode);
          s  <= AW'(req.range_start);
          e  <= AW'(req.range_end);
          a  <= AW'(req.lookup_address);
          t  <= req.region_kind;
        end
      end
      S_START: begin
        idx    <= '0;
        placed <= 1'b0;
        h_v    <= 1'b0;
        h_new  <= 1'b0;
        widx   <= '0;
        acc    <= '0;
        found  <= '0;
        if (op == OP_DEFINE && s >= e) sts <= STS_EMPTY;
        else if (op == OP_LOOKUP) sts <= STS_UNMAPPED;
        else sts <= STS_OK;
      end
      S_READ: begin
        if (rd_en) idx <= idx + CNT_W'(1);
      end
      S_DATA: begin
        if (op == OP_DEFINE) begin
          ent_f <= rd_f;
          ent_l <= rd_l;
          ent_k <= rd_k;
          lo_v  <= d_lo;
          hi_v  <= d_hi;
          nw_v  <= d_nw;
          lo_l  <= d_below ? rd_l : s - AW'(1);
          hi_f  <= d_above ? rd_f : e + AW'(1);
          if (d_nw) placed <= 1'b1;
        end else if (op == OP_LOOKUP) begin
          if (hit) begin
            found <= rd_k;
            sts   <= STS_OK;
          end
        end else if (rd_k == t) begin
          acc <= (sum >= SW'(TOTAL_CAP)) ? TOTAL_CAP : TOTAL_W'(sum);
        end
      end
      S_EMIT, S_TAIL, S_FLUSH: begin
        if (state == S_EMIT) begin
          if (lo_v) lo_v <= 1'b0;
          else if (nw_v) nw_v <= 1'b0;
          else hi_v <= 1'b0;
        end
        if (state == S_TAIL) placed <= 1'b1;
        h_v   <= nh_v;
        h_new <= nh_new;
        h_f   <= nh_f;
        h_l   <= nh_l;
        h_k   <= nh_k;
        if (em_wr) widx <= widx + WC_W'(1);
      end
      S_DONE: begin
        if (out_load) begin
          o_found <= found;
          o_total <= (op == OP_TOTAL) ? acc : '0;
          if (op == OP_DEFINE && sts != STS_EMPTY) begin
            o_status <= commit ? STS_OK : STS_FULL;
            o_used   <= commit ? USED_W'(widx) : USED_W'(count);
          end else begin
            o_status <= sts;
            o_used   <= USED_W'(count);
          end
        end
      end
      default: ;
    endcase
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REGIONS))
    else $error("region count above table size");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> idx < count)
    else $error("read past last region");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_EMIT || state == S_TAIL || state == S_FLUSH))
    else $error("table write outside define build");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == S_IDLE && out_v))
    else $error("result load did not return to idle");

  a_widx_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_START) |-> widx <= WC_W'(MAX_REGIONS + 2))
    else $error("new table grew past two extra entries");

endmodule

`default_nettype wire

// File: rtl/trmt_ram.sv
// ----------------------------------------------------------------------------
// trmt_ram: region table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trmt_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
